@@ design/ppl_pkg.sv @@
`timescale 1ns / 1ps

package ppl_pkg;

  // Phase accumulator and sample counter widths
  localparam int PHASE_BITS = 32;
  localparam int INDEX_BITS = 24;

  // Fixed field widths
  localparam int F0_W       = 16;
  localparam int ISR_W      = 32;
  localparam int PROD_W     = F0_W + ISR_W;
  localparam int PIDX_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Divider operand widths
  localparam int NUM_W = PHASE_BITS + 1;
  localparam int DEN_W = PHASE_BITS + 2;
  localparam int REM_W = PHASE_BITS + 3;
  localparam int DCNT_W = $clog2(FRAC_W);

  localparam logic [ISR_W-1:0]  ISR_RESET = 32'd366503876;
  localparam logic [FRAC_W-1:0] FRAC_SAT  = '1;

  // Register indexes
  localparam logic REG_INV_SAMPLE_RATE = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_OUT
  } ppl_state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ design/ppl_stream_if.sv @@
`timescale 1ns / 1ps

interface ppl_in_if import ppl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [F0_W-1:0] f0_hz_q4;
  logic            first;

  modport source (output valid, output f0_hz_q4, output first, input ready);
  modport sink   (input valid, input f0_hz_q4, input first, output ready);
endinterface

interface ppl_out_if import ppl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIDX_W-1:0] pulse_index;
  logic [FRAC_W-1:0] shift_frac;

  modport source (output valid, output pulse_index, output shift_frac, input ready);
  modport sink   (input valid, input pulse_index, input shift_frac, output ready);
endinterface

@@ design/ppl_apb_regs.sv @@
`timescale 1ns / 1ps

module ppl_apb_regs import ppl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [ISR_W-1:0]      inv_sample_rate
);

  logic [ISR_W-1:0] isr_r;
  logic             hit_isr;

  assign pready  = 1'b1;
  assign hit_isr = (paddr[2] == REG_INV_SAMPLE_RATE);

  // Write the rate register on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isr_r <= ISR_RESET;
    end else if (psel && penable && pwrite && hit_isr) begin
      isr_r <= ISR_W'(pwdata);
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit_isr) begin
      prdata = CFG_DATA_W'(isr_r);
    end
  end

  assign inv_sample_rate = isr_r;

endmodule

@@ design/ppl_div_unit.sv @@
`timescale 1ns / 1ps

module ppl_div_unit import ppl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [FRAC_W-1:0] quo_r;
  logic [REM_W-1:0]  rem_sh;
  logic              take;

  // One restoring step: shift, compare, subtract
  assign rem_sh = {rem_r[REM_W-2:0], 1'b0};
  assign take   = (rem_sh >= REM_W'(den_r));

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(FRAC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and quotient registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= REM_W'(req.num);
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? (rem_sh - REM_W'(den_r)) : rem_sh;
      quo_r <= {quo_r[FRAC_W-2:0], take};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

@@ design/pitch_pulse_locator.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake   | Word
// in_ch   | in        | valid/ready | f0_hz_q4[15:0], first
// out_ch  | out       | valid/ready | pulse_index[23:0], shift_frac[15:0]
// cfg_*   | in        | APB write   | inv_sample_rate at byte address 0
//
// A word passes S_IDLE, S_MUL, S_EVAL on a restart or when no pulse falls, adds
// S_OUT when the pulse saturates, and S_DIV and S_OUT when the serial quotient
// unit runs its 16 steps (the worst case). in_ch is ready only while idle.
// rst_n is synchronous: it clears phase, index and the held-sample flag, and
// sets the rate register to its reset value. A stalled out_ch holds a finished
// pulse; the next word is still taken but waits before its own result.

module pitch_pulse_locator import ppl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ppl_in_if.sink                in_ch,
  ppl_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  ppl_state_t state_r, state_nxt;

  logic [ISR_W-1:0]      isr;
  logic [F0_W-1:0]       f0_r;
  logic                  first_r;
  logic [PROD_W-1:0]     prod_c;
  logic [PHASE_BITS-1:0] step_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [INDEX_BITS-1:0] count_r;
  logic                  have_prev_r;
  logic [PIDX_W-1:0]     idx_r;
  logic [FRAC_W-1:0]     frac_r;
  logic                  out_valid_r;
  logic [PIDX_W-1:0]     out_idx_r;
  logic [FRAC_W-1:0]     out_frac_r;

  logic [PHASE_BITS-1:0] cur_c;
  logic [PHASE_BITS-1:0] diff_c;
  logic                  restart_c;
  logic                  pulse_c;
  logic                  cur_zero_c;
  logic                  out_free_c;

  logic in_ready_c;
  logic mul_load_c;
  logic eval_c;
  logic out_load_c;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ppl_apb_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (cfg_psel),
    .penable         (cfg_penable),
    .pwrite          (cfg_pwrite),
    .paddr           (cfg_paddr),
    .pwdata          (cfg_pwdata),
    .prdata          (cfg_prdata),
    .pready          (cfg_pready),
    .inv_sample_rate (isr)
  );

  ppl_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Phase step product, registered before use
  assign prod_c = PROD_W'(f0_r) * PROD_W'(isr);

  // Advance phase and test for a wrap of more than half a turn
  assign restart_c  = first_r || !have_prev_r;
  assign cur_c      = phase_r + step_r;
  assign diff_c     = (cur_c >= phase_r) ? (cur_c - phase_r) : (phase_r - cur_c);
  assign pulse_c    = (diff_c > (PHASE_BITS'(1) << (PHASE_BITS - 1)));
  assign cur_zero_c = (cur_c == '0);
  assign out_free_c = !out_valid_r || out_ch.ready;

  // Crossing fraction operands: num = one turn - prev, den = num + cur
  assign div_req.num   = (NUM_W'(1) << PHASE_BITS) - NUM_W'(phase_r);
  assign div_req.den   = DEN_W'(div_req.num) + DEN_W'(cur_c);
  assign div_req.start = eval_c && !restart_c && pulse_c && !cur_zero_c;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_EVAL;
      S_EVAL: begin
        if (restart_c || !pulse_c) begin
          state_nxt = S_IDLE;
        end else if (cur_zero_c) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV:  if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:  if (out_free_c) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_c = 1'b0;
    mul_load_c = 1'b0;
    eval_c     = 1'b0;
    out_load_c = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready_c = 1'b1;
      S_MUL:   mul_load_c = 1'b1;
      S_EVAL:  eval_c     = 1'b1;
      S_DIV:   ;
      S_OUT:   out_load_c = out_free_c;
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the accepted word and the step
  always_ff @(posedge clk) begin
    if (in_ready_c && in_ch.valid) begin
      f0_r    <= in_ch.f0_hz_q4;
      first_r <= in_ch.first;
    end
    if (mul_load_c) begin
      step_r <= prod_c[PROD_W-1 -: PHASE_BITS];
    end
  end

  // Phase, index and held-sample state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      count_r     <= '0;
      have_prev_r <= 1'b0;
    end else if (eval_c) begin
      if (restart_c) begin
        phase_r     <= step_r;
        count_r     <= '0;
        have_prev_r <= 1'b1;
      end else begin
        phase_r <= cur_c;
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Pulse payload before the output stage
  always_ff @(posedge clk) begin
    if (eval_c) begin
      idx_r  <= PIDX_W'(count_r);
      frac_r <= FRAC_SAT;
    end else if (div_rsp.done) begin
      frac_r <= div_rsp.quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_c) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_c) begin
      out_idx_r  <= idx_r;
      out_frac_r <= frac_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pulse_index = out_idx_r;
  assign out_ch.shift_frac  = out_frac_r;

  // Checks
  a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !div_rsp.busy)
    else $error("word accepted while quotient unit busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("quotient done outside divide state");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (eval_c && restart_c) |=> (count_r == '0 && have_prev_r))
    else $error("restart did not clear index");

  a_no_load_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load_c |-> (!out_valid_r || out_ch.ready))
    else $error("output register overwritten");

endmodule
